FILE: rtl/fcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcm_pkg
// Shared types, constants and helpers of the fat cluster chain manager.
// ----------------------------------------------------------------------------
package fcm_pkg;

    localparam int NUM_ENTRIES   = 4096;
    localparam int CLUSTER_BYTES = 1024;
    localparam int FIRST_DATA    = 10;
    localparam int ROOT_ENTRY    = 9;

    localparam int ADDR_W   = $clog2(NUM_ENTRIES);
    localparam int IDX_W    = ADDR_W + 1;
    localparam int CL_SHIFT = $clog2(CLUSTER_BYTES);
    localparam int SIZE_W   = 23;
    localparam int NEED_W   = SIZE_W + 1 - CL_SHIFT;
    localparam int ENTRY_W  = 16;
    localparam int SIZE_CAP = 4194304;

    typedef enum logic [2:0] {
        KIND_FORMAT = 3'd0,
        KIND_WRITE  = 3'd1,
        KIND_READ   = 3'd2,
        KIND_FREE   = 3'd3,
        KIND_ALLOC  = 3'd4,
        KIND_EXTEND = 3'd5
    } kind_e;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BROKEN = 2'd2
    } status_e;

    typedef enum logic [1:0] {
        CFG_FREE     = 2'd0,
        CFG_EOF      = 2'd1,
        CFG_RESERVED = 2'd2,
        CFG_BOOT     = 2'd3
    } cfg_idx_e;

    typedef struct packed {
        logic [2:0]         kind;
        logic [11:0]        start_cluster;
        logic [15:0]        entry_value;
        logic [SIZE_W-1:0]  file_size;
        logic [SIZE_W-1:0]  byte_length;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [11:0]        first_cluster;
        logic [15:0]        read_value;
        logic [SIZE_W-1:0]  new_size;
        logic [12:0]        cluster_count;
    } rsp_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] free_mark;
        logic [ENTRY_W-1:0] eof_mark;
        logic [ENTRY_W-1:0] reserved_mark;
        logic [ENTRY_W-1:0] boot_mark;
    } marks_t;

    localparam marks_t RESET_MARKS = '{
        free_mark:     16'd0,
        eof_mark:      16'd32767,
        reserved_mark: 16'd32766,
        boot_mark:     16'd32765
    };

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [ENTRY_W-1:0] wdata;
        logic [ADDR_W-1:0]  raddr;
    } mem_req_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_FMT,
        S_WRITE,
        S_READ_RD,
        S_READ_EV,
        S_WALK_RD,
        S_WALK_EV,
        S_FREE_RD,
        S_FREE_EV,
        S_APREP,
        S_XPREP,
        S_CNT_RD,
        S_CNT_EV,
        S_TAKE_RD,
        S_TAKE_EV,
        S_TAKE_LINK,
        S_LAST_LINK,
        S_DONE
    } state_e;

    // fixed layout of a freshly formatted table
    function automatic logic [ENTRY_W-1:0] fmt_value(input logic [ADDR_W-1:0] idx,
                                                     input marks_t m);
        logic [ENTRY_W-1:0] v;
        if (idx == ADDR_W'(0))
            v = m.boot_mark;
        else if (idx == ADDR_W'(ROOT_ENTRY))
            v = m.eof_mark;
        else if (idx < ADDR_W'(FIRST_DATA))
            v = m.reserved_mark;
        else
            v = m.free_mark;
        return v;
    endfunction

endpackage

FILE: rtl/fcm_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcm_table
// Allocation table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fcm_table (
    input  logic                          clk,
    input  fcm_pkg::mem_req_t             mem,
    output logic [fcm_pkg::ENTRY_W-1:0]   rdata
);

    logic [fcm_pkg::ENTRY_W-1:0] mem_array [fcm_pkg::NUM_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (mem.we)
        begin
            mem_array[mem.waddr] <= mem.wdata;
        end
        rdata <= mem_array[mem.raddr];
    end

endmodule

FILE: rtl/fcm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcm_seq
// Operation sequencer: walks, counts and takes table entries one at a time.
// ----------------------------------------------------------------------------
module fcm_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fcm_pkg::marks_t               marks,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  fcm_pkg::req_t                 req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output fcm_pkg::rsp_t                 rsp_data,
    output fcm_pkg::mem_req_t             mem,
    input  logic [fcm_pkg::ENTRY_W-1:0]   rdata
);

    localparam int AW = fcm_pkg::ADDR_W;
    localparam int IW = fcm_pkg::IDX_W;
    localparam int NW = fcm_pkg::NEED_W;
    localparam int SW = fcm_pkg::SIZE_W;
    localparam int EW = fcm_pkg::ENTRY_W;
    localparam int CL_W = fcm_pkg::CL_SHIFT;

    fcm_pkg::state_e state_reg, state_next;
    logic [2:0]    kind_reg, kind_next;
    logic [11:0]   start_reg, start_next;
    logic [EW-1:0] entry_reg, entry_next;
    logic [SW-1:0] fsize_reg, fsize_next;
    logic [SW-1:0] blen_reg, blen_next;
    logic [EW-1:0] cur_reg, cur_next;
    logic [IW-1:0] n_reg, n_next;
    logic [AW-1:0] last_reg, last_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] fcount_reg, fcount_next;
    logic [NW-1:0] need_reg, need_next;
    logic [NW-1:0] got_reg, got_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] prev_reg, prev_next;
    fcm_pkg::rsp_t res_reg, res_next;
    fcm_pkg::rsp_t out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    // extend and allocate arithmetic
    logic [CL_W-1:0] used;
    logic [CL_W:0]   space;
    logic [SW-1:0]   rest;
    logic [SW:0]     rest_round;
    logic [SW:0]     blen_round;
    logic [SW:0]     size_sum;
    logic [SW-1:0]   size_sat;
    logic [NW-1:0]   need_x;
    logic [NW-1:0]   need_a;
    logic            is_free;

    always_comb
    begin
        used = fsize_reg[CL_W-1:0];
        space = (used != '0) ? ((CL_W+1)'(fcm_pkg::CLUSTER_BYTES) - {1'b0, used}) : '0;
        rest = blen_reg;
        if (last_reg != '0 && space != '0)
        begin
            rest = (blen_reg > SW'(space)) ? (blen_reg - SW'(space)) : '0;
        end
        rest_round = {1'b0, rest} + (SW+1)'(fcm_pkg::CLUSTER_BYTES - 1);
        blen_round = {1'b0, blen_reg} + (SW+1)'(fcm_pkg::CLUSTER_BYTES - 1);
        need_x = rest_round[SW:CL_W];
        need_a = blen_round[SW:CL_W];
        size_sum = {1'b0, fsize_reg} + {1'b0, blen_reg};
        size_sat = (size_sum > (SW+1)'(fcm_pkg::SIZE_CAP)) ?
                   SW'(fcm_pkg::SIZE_CAP) : size_sum[SW-1:0];
        is_free = (rdata == marks.free_mark);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fcm_pkg::S_CLEAR;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        start_reg  <= start_next;
        entry_reg  <= entry_next;
        fsize_reg  <= fsize_next;
        blen_reg   <= blen_next;
        cur_reg    <= cur_next;
        n_reg      <= n_next;
        last_reg   <= last_next;
        fcount_reg <= fcount_next;
        need_reg   <= need_next;
        got_reg    <= got_next;
        head_reg   <= head_next;
        prev_reg   <= prev_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        start_next     = start_reg;
        entry_next     = entry_reg;
        fsize_next     = fsize_reg;
        blen_next      = blen_reg;
        cur_next       = cur_reg;
        n_next         = n_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        fcount_next    = fcount_reg;
        need_next      = need_reg;
        got_next       = got_reg;
        head_next      = head_reg;
        prev_next      = prev_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem.we    = 1'b0;
        mem.waddr = idx_reg[AW-1:0];
        mem.wdata = '0;
        mem.raddr = cur_reg[AW-1:0];

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            fcm_pkg::S_CLEAR:
            begin
                mem.we    = 1'b1;
                mem.wdata = fcm_pkg::fmt_value(idx_reg[AW-1:0], fcm_pkg::RESET_MARKS);
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == IW'(fcm_pkg::NUM_ENTRIES - 1))
                begin
                    state_next = fcm_pkg::S_IDLE;
                end
            end
            fcm_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next  = req_data.kind;
                    start_next = req_data.start_cluster;
                    entry_next = req_data.entry_value;
                    fsize_next = req_data.file_size;
                    blen_next  = req_data.byte_length;
                    cur_next   = EW'(req_data.start_cluster);
                    n_next     = '0;
                    last_next  = '0;
                    idx_next   = '0;
                    res_next   = '0;
                    case (req_data.kind)
                        fcm_pkg::KIND_FORMAT: state_next = fcm_pkg::S_FMT;
                        fcm_pkg::KIND_WRITE:  state_next = fcm_pkg::S_WRITE;
                        fcm_pkg::KIND_READ:   state_next = fcm_pkg::S_READ_RD;
                        fcm_pkg::KIND_FREE,
                        fcm_pkg::KIND_EXTEND: state_next = fcm_pkg::S_WALK_RD;
                        fcm_pkg::KIND_ALLOC:  state_next = fcm_pkg::S_APREP;
                        default:              state_next = fcm_pkg::S_DONE;
                    endcase
                end
            end
            fcm_pkg::S_FMT:
            begin
                mem.we    = 1'b1;
                mem.wdata = fcm_pkg::fmt_value(idx_reg[AW-1:0], marks);
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == IW'(fcm_pkg::NUM_ENTRIES - 1))
                begin
                    state_next = fcm_pkg::S_DONE;
                end
            end
            fcm_pkg::S_WRITE:
            begin
                mem.we     = 1'b1;
                mem.waddr  = start_reg;
                mem.wdata  = entry_reg;
                state_next = fcm_pkg::S_DONE;
            end
            fcm_pkg::S_READ_RD:
            begin
                mem.raddr  = start_reg;
                state_next = fcm_pkg::S_READ_EV;
            end
            fcm_pkg::S_READ_EV:
            begin
                res_next.read_value = rdata;
                state_next = fcm_pkg::S_DONE;
            end
            fcm_pkg::S_WALK_RD:
            begin
                if (cur_reg == '0 || cur_reg == marks.eof_mark)
                begin
                    if (kind_reg == fcm_pkg::KIND_FREE)
                    begin
                        cur_next   = EW'(start_reg);
                        idx_next   = '0;
                        state_next = fcm_pkg::S_FREE_RD;
                    end
                    else
                    begin
                        state_next = fcm_pkg::S_XPREP;
                    end
                end
                else if (cur_reg[EW-1:AW] != '0 || n_reg == IW'(fcm_pkg::NUM_ENTRIES))
                begin
                    res_next        = '0;
                    res_next.status = fcm_pkg::ST_BROKEN;
                    state_next      = fcm_pkg::S_DONE;
                end
                else
                begin
                    n_next     = n_reg + 1'b1;
                    last_next  = cur_reg[AW-1:0];
                    state_next = fcm_pkg::S_WALK_EV;
                end
            end
            fcm_pkg::S_WALK_EV:
            begin
                cur_next   = rdata;
                state_next = fcm_pkg::S_WALK_RD;
            end
            fcm_pkg::S_FREE_RD:
            begin
                if (idx_reg == n_reg)
                begin
                    res_next.cluster_count = n_reg;
                    state_next = fcm_pkg::S_DONE;
                end
                else
                begin
                    state_next = fcm_pkg::S_FREE_EV;
                end
            end
            fcm_pkg::S_FREE_EV:
            begin
                mem.we     = 1'b1;
                mem.waddr  = cur_reg[AW-1:0];
                mem.wdata  = marks.free_mark;
                cur_next   = rdata;
                idx_next   = idx_reg + 1'b1;
                state_next = fcm_pkg::S_FREE_RD;
            end
            fcm_pkg::S_APREP:
            begin
                need_next   = need_a;
                idx_next    = IW'(fcm_pkg::FIRST_DATA);
                fcount_next = '0;
                state_next  = (need_a == '0) ? fcm_pkg::S_DONE : fcm_pkg::S_CNT_RD;
            end
            fcm_pkg::S_XPREP:
            begin
                res_next.first_cluster = start_reg;
                res_next.new_size      = fsize_reg;
                need_next   = need_x;
                idx_next    = IW'(fcm_pkg::FIRST_DATA);
                fcount_next = '0;
                if (blen_reg == '0)
                begin
                    state_next = fcm_pkg::S_DONE;
                end
                else if (need_x == '0)
                begin
                    res_next.new_size = size_sat;
                    state_next = fcm_pkg::S_DONE;
                end
                else
                begin
                    state_next = fcm_pkg::S_CNT_RD;
                end
            end
            fcm_pkg::S_CNT_RD:
            begin
                mem.raddr = idx_reg[AW-1:0];
                if (idx_reg == IW'(fcm_pkg::NUM_ENTRIES))
                begin
                    if (NW'(fcount_reg) < need_reg)
                    begin
                        res_next.status = fcm_pkg::ST_FULL;
                        state_next = fcm_pkg::S_DONE;
                    end
                    else
                    begin
                        idx_next   = IW'(fcm_pkg::FIRST_DATA);
                        got_next   = '0;
                        state_next = fcm_pkg::S_TAKE_RD;
                    end
                end
                else
                begin
                    state_next = fcm_pkg::S_CNT_EV;
                end
            end
            fcm_pkg::S_CNT_EV:
            begin
                if (is_free)
                begin
                    fcount_next = fcount_reg + 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = fcm_pkg::S_CNT_RD;
            end
            fcm_pkg::S_TAKE_RD:
            begin
                mem.raddr = idx_reg[AW-1:0];
                if (got_reg == need_reg)
                begin
                    res_next.cluster_count = need_reg[IW-1:0];
                    if (kind_reg == fcm_pkg::KIND_ALLOC)
                    begin
                        res_next.first_cluster = head_reg;
                        res_next.new_size      = blen_reg;
                        state_next = fcm_pkg::S_DONE;
                    end
                    else
                    begin
                        res_next.new_size = size_sat;
                        if (start_reg == '0)
                        begin
                            res_next.first_cluster = head_reg;
                            state_next = fcm_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = fcm_pkg::S_LAST_LINK;
                        end
                    end
                end
                else
                begin
                    state_next = fcm_pkg::S_TAKE_EV;
                end
            end
            fcm_pkg::S_TAKE_EV:
            begin
                if (is_free)
                begin
                    mem.we    = 1'b1;
                    mem.wdata = marks.eof_mark;
                    got_next  = got_reg + 1'b1;
                    if (got_reg == '0)
                    begin
                        head_next  = idx_reg[AW-1:0];
                        prev_next  = idx_reg[AW-1:0];
                        idx_next   = idx_reg + 1'b1;
                        state_next = fcm_pkg::S_TAKE_RD;
                    end
                    else
                    begin
                        state_next = fcm_pkg::S_TAKE_LINK;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = fcm_pkg::S_TAKE_RD;
                end
            end
            fcm_pkg::S_TAKE_LINK:
            begin
                // previous cluster of the new chain points here
                mem.we     = 1'b1;
                mem.waddr  = prev_reg;
                mem.wdata  = EW'(idx_reg[AW-1:0]);
                prev_next  = idx_reg[AW-1:0];
                idx_next   = idx_reg + 1'b1;
                state_next = fcm_pkg::S_TAKE_RD;
            end
            fcm_pkg::S_LAST_LINK:
            begin
                mem.we     = 1'b1;
                mem.waddr  = last_reg;
                mem.wdata  = EW'(head_reg);
                state_next = fcm_pkg::S_DONE;
            end
            fcm_pkg::S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = fcm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fcm_pkg::S_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != fcm_pkg::S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fcm_pkg::S_WALK_EV) |-> (n_reg <= IW'(fcm_pkg::NUM_ENTRIES)))
        else $error("walk count past table size");

    a_take_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fcm_pkg::S_TAKE_EV) |-> (got_reg < need_reg))
        else $error("took more clusters than needed");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fcm_pkg::S_IDLE) |-> !mem.we)
        else $error("table write while idle");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == fcm_pkg::S_DONE))
        else $error("response word without finished operation");

endmodule

FILE: rtl/fat_cluster_chain_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_cluster_chain_manager
// File allocation table keeper: format, entry access, chain free/alloc/extend.
// ----------------------------------------------------------------------------
// write stores one entry, read fetches one entry, format rewrites every entry
// free walks the chain link by link, then frees each link
// allocate counts free entries, then takes entries one by one;
//   extend walks the chain first, then counts and takes like allocate
// one operation at a time: req_stall is high until the sequencer is idle again
// reset: a clearing pass lays out the table, req_stall high meanwhile
module fat_cluster_chain_manager (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  fcm_pkg::req_t        req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output fcm_pkg::rsp_t        rsp_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    fcm_pkg::marks_t   marks_reg, marks_next;
    fcm_pkg::mem_req_t mem;
    logic [fcm_pkg::ENTRY_W-1:0] rdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        marks_next = marks_reg;
        if (cfg_valid)
        begin
            unique case (fcm_pkg::cfg_idx_e'(cfg_index))
                fcm_pkg::CFG_FREE:     marks_next.free_mark     = cfg_data;
                fcm_pkg::CFG_EOF:      marks_next.eof_mark      = cfg_data;
                fcm_pkg::CFG_RESERVED: marks_next.reserved_mark = cfg_data;
                fcm_pkg::CFG_BOOT:     marks_next.boot_mark     = cfg_data;
                default:               marks_next = marks_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg <= fcm_pkg::RESET_MARKS;
        end
        else
        begin
            marks_reg <= marks_next;
        end
    end

    fcm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .marks     (marks_reg),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .mem       (mem),
        .rdata     (rdata)
    );

    fcm_table u_table (
        .clk   (clk),
        .mem   (mem),
        .rdata (rdata)
    );

endmodule
